@@ src/lopd_pkg.sv @@
// lopd_pkg: codes, command and status types for the line-printer overprint decoder
// shared by the controller, the datapath and the top level; no dependencies
`timescale 1ns / 1ps

package lopd_pkg;

	// input item kinds (tuser)
	localparam logic [1:0] FUNC_CODE   = 2'd0;
	localparam logic [1:0] FUNC_PSTART = 2'd1;
	localparam logic [1:0] FUNC_EOJ    = 2'd2;

	// printer stream codes
	localparam logic [7:0] CODE_REPEAT   = 8'o177;
	localparam logic [7:0] CODE_STOP_A   = 8'o174;
	localparam logic [7:0] CODE_STOP_B   = 8'o175;
	localparam logic [7:0] CODE_CHAR_MAX = 8'o140;
	localparam logic [7:0] CODE_CR       = 8'o141;
	localparam logic [7:0] CODE_FF       = 8'o176;
	localparam logic [7:0] NL_BASE       = 8'o141;

	localparam logic [6:0] BLANK_RESET = 7'd15;

	// decoded item classes
	localparam logic [3:0] CL_IGNORE = 4'd0;
	localparam logic [3:0] CL_PSTART = 4'd1;
	localparam logic [3:0] CL_EOJ    = 4'd2;
	localparam logic [3:0] CL_REPCNT = 4'd3;
	localparam logic [3:0] CL_REPARM = 4'd4;
	localparam logic [3:0] CL_STOP   = 4'd5;
	localparam logic [3:0] CL_COLSET = 4'd6;
	localparam logic [3:0] CL_CHAR   = 4'd7;
	localparam logic [3:0] CL_CR     = 4'd8;
	localparam logic [3:0] CL_FF     = 4'd9;
	localparam logic [3:0] CL_NL     = 4'd10;

	typedef struct packed {
		logic load_item;
		logic exec;
		logic pl_rd;
		logic pl_wr;
		logic fl_rd;
		logic fl_acc;
		logic emit;
		logic blank;
	} cmd_t;

	typedef struct packed {
		logic [3:0] cls;
		logic       cnt_zero;
		logic       col_past;
		logic       grp_end;
		logic       at_end;
		logic       len_zero;
		logic       out_free;
	} sts_t;

	function automatic logic [3:0] classify(input logic [1:0] f, input logic [7:0] b,
			input logic stop, input logic rep);
		logic [3:0] c;
		c = CL_IGNORE;
		if (f == FUNC_PSTART)
			c = CL_PSTART;
		else if (f == FUNC_EOJ)
			c = CL_EOJ;
		else if (f != FUNC_CODE || stop)
			c = CL_IGNORE;
		else if (rep)
			c = CL_REPCNT;
		else if (b == CODE_REPEAT)
			c = CL_REPARM;
		else if (b == 8'd0 || b == CODE_STOP_A || b == CODE_STOP_B)
			c = CL_STOP;
		else if (b[7])
			c = CL_COLSET;
		else if (b <= CODE_CHAR_MAX)
			c = CL_CHAR;
		else if (b == CODE_CR)
			c = CL_CR;
		else if (b == CODE_FF)
			c = CL_FF;
		else
			c = CL_NL;
		return c;
	endfunction

endpackage

@@ src/lopd_ctrl.sv @@
// lopd_ctrl: sequencer for item decode, character placement and line flush
// uses lopd_pkg command and status types; drives lopd_datapath
`timescale 1ns / 1ps

module lopd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  lopd_pkg::sts_t sts,
	output lopd_pkg::cmd_t cmd
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_DEC     = 3'd1;
	localparam logic [2:0] S_PL_RD   = 3'd2;
	localparam logic [2:0] S_PL_WR   = 3'd3;
	localparam logic [2:0] S_FL_RD   = 3'd4;
	localparam logic [2:0] S_FL_ACC  = 3'd5;
	localparam logic [2:0] S_FL_EMIT = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				cmd.exec = 1'b1;
				case (sts.cls)
					lopd_pkg::CL_CHAR, lopd_pkg::CL_REPCNT: state_d = S_PL_RD;
					lopd_pkg::CL_NL, lopd_pkg::CL_FF: begin
						// empty line still gives one result
						state_d = sts.len_zero ? S_FL_EMIT : S_FL_RD;
					end
					lopd_pkg::CL_EOJ: begin
						if (sts.len_zero) begin
							cmd.blank = 1'b1;
							state_d = S_IDLE;
						end else begin
							state_d = S_FL_RD;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_PL_RD: begin
				if (sts.cnt_zero || sts.col_past) begin
					state_d = S_IDLE;
				end else begin
					cmd.pl_rd = 1'b1;
					state_d = S_PL_WR;
				end
			end
			S_PL_WR: begin
				cmd.pl_wr = 1'b1;
				state_d = S_PL_RD;
			end
			S_FL_RD: begin
				cmd.fl_rd = 1'b1;
				state_d = S_FL_ACC;
			end
			S_FL_ACC: begin
				cmd.fl_acc = 1'b1;
				state_d = sts.grp_end ? S_FL_EMIT : S_FL_RD;
			end
			S_FL_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.at_end) begin
						cmd.blank = !sts.len_zero;
						state_d = S_IDLE;
					end else begin
						state_d = S_FL_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ src/lopd_datapath.sv @@
// lopd_datapath: line store memory, column and extent registers, flush packer, output register
// uses lopd_pkg codes and types; sequenced by lopd_ctrl
`timescale 1ns / 1ps

module lopd_datapath #(
	parameter int LINE_WIDTH = 128
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [1:0]     in_func,
	input  logic [7:0]     in_byte,
	input  logic           cfg_valid,
	input  logic [6:0]     cfg_data,
	input  logic           out_ready,
	input  lopd_pkg::cmd_t cmd,
	output lopd_pkg::sts_t sts,
	output logic           out_valid,
	output logic [63:0]    out_chars,
	output logic [3:0]     out_count,
	output logic [4:0]     out_nl,
	output logic           out_ff,
	output logic           out_last
);

	localparam int AW = $clog2(LINE_WIDTH);
	localparam int CW = $clog2(LINE_WIDTH + 1);
	localparam logic [CW-1:0] COL_END = CW'(LINE_WIDTH);

	logic [6:0]      mem_q [LINE_WIDTH];
	logic [LINE_WIDTH-1:0] vld_q;
	logic [6:0]      rd_q;
	logic            vld_rd_q;
	logic [AW-1:0]   rd_addr;
	logic [6:0]      eff_char;

	logic [1:0]      func_q;
	logic [7:0]      byte_q;
	logic            stopped_q;
	logic            rep_q;
	logic [CW-1:0]   column_q;
	logic [CW-1:0]   highest_q;
	logic [6:0]      last_char_q;
	logic [7:0]      cnt_q;
	logic [6:0]      blank_code_q;
	logic [6:0]      blank_clr_q;
	logic [CW-1:0]   ptr_q;
	logic [CW-1:0]   ptr_inc;
	logic [CW-1:0]   col_inc;
	logic [63:0]     word_q;
	logic [3:0]      wcnt_q;
	logic [4:0]      nl_q;
	logic            ff_q;
	logic            out_valid_q;
	logic [3:0]      cls;
	logic            we;
	logic            init_flush;

	assign cls      = lopd_pkg::classify(func_q, byte_q, stopped_q, rep_q);
	// never-written columns read as the blank code in force at the last clear
	assign eff_char = vld_rd_q ? rd_q : blank_clr_q;
	assign rd_addr  = cmd.fl_rd ? ptr_q[AW-1:0] : column_q[AW-1:0];
	assign ptr_inc  = CW'(ptr_q + 1'b1);
	assign col_inc  = CW'(column_q + 1'b1);
	assign we       = cmd.pl_wr && (eff_char == blank_code_q);
	assign init_flush = cmd.exec &&
		(cls == lopd_pkg::CL_NL || cls == lopd_pkg::CL_FF || cls == lopd_pkg::CL_EOJ);

	assign sts.cls      = cls;
	assign sts.cnt_zero = (cnt_q == 8'd0);
	assign sts.col_past = (column_q >= COL_END);
	assign sts.grp_end  = (ptr_q[2:0] == 3'd7) || (ptr_inc == highest_q);
	assign sts.at_end   = (ptr_q == highest_q);
	assign sts.len_zero = (highest_q == '0);
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[column_q[AW-1:0]] <= last_char_q;
		if (cmd.pl_rd || cmd.fl_rd) begin
			rd_q     <= mem_q[rd_addr];
			vld_rd_q <= vld_q[rd_addr];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			func_q <= in_func;
			byte_q <= in_byte;
		end
		if (init_flush) begin
			word_q <= '0;
			wcnt_q <= '0;
			if (cls == lopd_pkg::CL_NL) begin
				nl_q <= 5'(byte_q - lopd_pkg::NL_BASE);
				ff_q <= 1'b0;
			end else if (cls == lopd_pkg::CL_FF) begin
				nl_q <= 5'd0;
				ff_q <= 1'b1;
			end else begin
				nl_q <= 5'd1;
				ff_q <= 1'b0;
			end
		end
		if (cmd.fl_acc) begin
			if (ptr_q[2:0] == 3'd0)
				word_q <= {56'd0, 1'b0, eff_char};
			else
				word_q[{ptr_q[2:0], 3'b000} +: 8] <= {1'b0, eff_char};
			wcnt_q <= 4'({1'b0, ptr_q[2:0]} + 4'd1);
		end
		if (cmd.emit) begin
			out_chars <= word_q;
			out_count <= wcnt_q;
			out_nl    <= sts.at_end ? nl_q : 5'd0;
			out_ff    <= sts.at_end ? ff_q : 1'b0;
			out_last  <= sts.at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stopped_q    <= 1'b0;
			rep_q        <= 1'b0;
			column_q     <= '0;
			highest_q    <= '0;
			last_char_q  <= 7'd0;
			cnt_q        <= 8'd0;
			ptr_q        <= '0;
			vld_q        <= '0;
			blank_code_q <= lopd_pkg::BLANK_RESET;
			blank_clr_q  <= lopd_pkg::BLANK_RESET;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid)
				blank_code_q <= cfg_data;
			if (cmd.exec) begin
				case (cls)
					lopd_pkg::CL_PSTART, lopd_pkg::CL_EOJ: begin
						stopped_q <= 1'b0;
						rep_q     <= 1'b0;
					end
					lopd_pkg::CL_REPCNT: begin
						rep_q <= 1'b0;
						cnt_q <= byte_q;
					end
					lopd_pkg::CL_REPARM: rep_q <= 1'b1;
					lopd_pkg::CL_STOP:   stopped_q <= 1'b1;
					lopd_pkg::CL_COLSET: begin
						if ({25'd0, byte_q[6:0]} > LINE_WIDTH)
							column_q <= COL_END;
						else
							column_q <= CW'(byte_q[6:0]);
					end
					lopd_pkg::CL_CHAR: begin
						last_char_q <= 7'(byte_q - 8'd1);
						cnt_q       <= 8'd1;
					end
					lopd_pkg::CL_CR: column_q <= '0;
					default: ;
				endcase
			end
			if (init_flush)
				ptr_q <= '0;
			if (cmd.pl_wr) begin
				if (col_inc > highest_q)
					highest_q <= col_inc;
				if (we)
					vld_q[column_q[AW-1:0]] <= 1'b1;
				column_q <= col_inc;
				cnt_q    <= 8'(cnt_q - 8'd1);
			end
			if (cmd.fl_acc)
				ptr_q <= ptr_inc;
			if (cmd.blank) begin
				vld_q       <= '0;
				column_q    <= '0;
				highest_q   <= '0;
				blank_clr_q <= blank_code_q;
			end
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ src/printer_line_overprint_decoder.sv @@
// printer_line_overprint_decoder: top level over lopd_ctrl and lopd_datapath, uses lopd_pkg
// steps: a code byte is transferred, then decoded; placing reads and then writes each column,
//   with a last check that ends it; flush: each column is read from the single-port line store
//   and packed, and each result is emitted once the output register is free
// results wait in an output register; the next item is taken while one waits there
// reset: asynchronous; the line reads blank at once through per-column valid bits, no clear pass
`timescale 1ns / 1ps

module printer_line_overprint_decoder #(
	parameter int LINE_WIDTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // code_byte[7:0]
	input  logic [1:0]  s_axis_tuser,  // func[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,  // chars[63:0], char_count[67:64], newlines[72:68], form_feed[73]
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data       // blank_code
);

	lopd_pkg::cmd_t cmd;
	lopd_pkg::sts_t sts;
	logic [63:0] chars;
	logic [3:0]  char_count;
	logic [4:0]  newlines;
	logic        form_feed;

	assign cfg_ready = 1'b1;

	lopd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lopd_datapath #(
		.LINE_WIDTH (LINE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_func   (s_axis_tuser),
		.in_byte   (s_axis_tdata),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_chars (chars),
		.out_count (char_count),
		.out_nl    (newlines),
		.out_ff    (form_feed),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {6'd0, form_feed, newlines, char_count, chars};

	// no result loaded over one that is still held
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result loaded while output register held");

	// busy right after an item transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input ready right after transfer");

	// final result of a flush carries tlast
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && sts.at_end) |=> (m_axis_tvalid && m_axis_tlast))
		else $error("flush end without tlast");

	// the line is blanked only on the final result or an empty end of job
	a_blank: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.blank |-> ((cmd.emit && sts.at_end) || (cmd.exec && sts.len_zero)))
		else $error("line blanked outside flush end");

endmodule
